[src/lbsm_pkg.sv]
package lbsm_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 15;

  // Division lanes handled side by side in each cell (x and y)
  localparam int LANES = 2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_TARGET_WIDTH  = 2'd2,
    CFG_TARGET_HEIGHT = 2'd3
  } cfg_idx_t;

endpackage

[src/lbsm_div_cell.sv]
// One restoring-division step for two lanes, with an elastic valid register.
module lbsm_div_cell #(
  parameter int N  = lbsm_pkg::COORD_BITS_DEF,
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  v_i,
  output logic                                  rdy_o,
  input  logic [lbsm_pkg::LANES-1:0][N-1:0]     rem_i,
  input  logic [lbsm_pkg::LANES-1:0][N-1:0]     dvd_i,
  input  logic [lbsm_pkg::LANES-1:0][N-1:0]     quo_i,
  input  logic [lbsm_pkg::LANES-1:0][N-1:0]     dvs_i,
  input  logic [SW-1:0]                         side_i,
  output logic                                  v_o,
  input  logic                                  rdy_i,
  output logic [lbsm_pkg::LANES-1:0][N-1:0]     rem_o,
  output logic [lbsm_pkg::LANES-1:0][N-1:0]     dvd_o,
  output logic [lbsm_pkg::LANES-1:0][N-1:0]     quo_o,
  output logic [lbsm_pkg::LANES-1:0][N-1:0]     dvs_o,
  output logic [SW-1:0]                         side_o
);

  logic                                 v_r;
  logic [lbsm_pkg::LANES-1:0][N-1:0]    rem_r, rem_nxt;
  logic [lbsm_pkg::LANES-1:0][N-1:0]    dvd_r, dvd_nxt;
  logic [lbsm_pkg::LANES-1:0][N-1:0]    quo_r, quo_nxt;
  logic [lbsm_pkg::LANES-1:0][N-1:0]    dvs_r;
  logic [SW-1:0]                        side_r;
  logic [lbsm_pkg::LANES-1:0][N:0]      trial, diff;
  logic [lbsm_pkg::LANES-1:0]           fits;

  assign rdy_o = !v_r || rdy_i;

  // Shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    for (int l = 0; l < lbsm_pkg::LANES; l++) begin
      trial[l]   = {rem_i[l], dvd_i[l][N-1]};
      diff[l]    = trial[l] - {1'b0, dvs_i[l]};
      fits[l]    = (trial[l] >= {1'b0, dvs_i[l]});
      rem_nxt[l] = fits[l] ? diff[l][N-1:0] : trial[l][N-1:0];
      dvd_nxt[l] = {dvd_i[l][N-2:0], 1'b0};
      quo_nxt[l] = {quo_i[l][N-2:0], fits[l]};
    end
  end

  // Advance when downstream takes the beat or this cell is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      rem_r  <= rem_nxt;
      dvd_r  <= dvd_nxt;
      quo_r  <= quo_nxt;
      dvs_r  <= dvs_i;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign dvd_o  = dvd_r;
  assign quo_o  = quo_r;
  assign dvs_o  = dvs_r;
  assign side_o = side_r;

endmodule

[src/lbsm_divider.sv]
// Chain of N division cells; two lanes of 2N-by-N division, quotient known below 2^N.
module lbsm_divider #(
  parameter int N  = lbsm_pkg::COORD_BITS_DEF,
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  v_i,
  output logic                                  rdy_o,
  input  logic [lbsm_pkg::LANES-1:0][2*N-1:0]   dividend_i,
  input  logic [lbsm_pkg::LANES-1:0][N-1:0]     divisor_i,
  input  logic [SW-1:0]                         side_i,
  output logic                                  v_o,
  input  logic                                  rdy_i,
  output logic [lbsm_pkg::LANES-1:0][N-1:0]     quo_o,
  output logic [SW-1:0]                         side_o
);

  logic [N:0]                                   v_c, rdy_c;
  logic [N:0][lbsm_pkg::LANES-1:0][N-1:0]       rem_c, dvd_c, quo_c, dvs_c;
  logic [N:0][SW-1:0]                           side_c;

  // Load the chain head: upper half as partial remainder
  always_comb begin
    for (int l = 0; l < lbsm_pkg::LANES; l++) begin
      rem_c[0][l] = dividend_i[l][2*N-1:N];
      dvd_c[0][l] = dividend_i[l][N-1:0];
      quo_c[0][l] = '0;
      dvs_c[0][l] = divisor_i[l];
    end
  end
  assign v_c[0]    = v_i;
  assign side_c[0] = side_i;
  assign rdy_o     = rdy_c[0];

  for (genvar k = 0; k < N; k++) begin : g_cell
    lbsm_div_cell #(.N(N), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (v_c[k]),
      .rdy_o  (rdy_c[k]),
      .rem_i  (rem_c[k]),
      .dvd_i  (dvd_c[k]),
      .quo_i  (quo_c[k]),
      .dvs_i  (dvs_c[k]),
      .side_i (side_c[k]),
      .v_o    (v_c[k+1]),
      .rdy_i  (rdy_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .dvd_o  (dvd_c[k+1]),
      .quo_o  (quo_c[k+1]),
      .dvs_o  (dvs_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  assign rdy_c[N] = rdy_i;
  assign v_o      = v_c[N];
  assign quo_o    = quo_c[N];
  assign side_o   = side_c[N];

endmodule

[src/letterbox_nearest_scaler_map_core.sv]
// Letterbox nearest scaler map: takes one destination pixel per beat and returns, one beat
// each, the empty/out-of-frame/bar/letterbox flags and the floor-mapped source column and
// row. It sustains one pixel per clock while out_stall is low; the pipeline holds two chains
// of COORD_BITS restoring-division cells (fit extent, then source position). The user must
// write sizes via cfg_* only while no pixel is in flight; the block does not enforce it.
module letterbox_nearest_scaler_map_core #(
  parameter int COORD_BITS = lbsm_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lbsm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [COORD_BITS-1:0]             in_pixel_column,
  input  logic [COORD_BITS-1:0]             in_pixel_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_frame_empty,
  output logic                              out_out_of_frame,
  output logic                              out_in_bar,
  output logic                              out_letterboxed,
  output logic [COORD_BITS-1:0]             out_source_column,
  output logic [COORD_BITS-1:0]             out_source_row
);

  localparam int N = COORD_BITS;
  localparam logic [N-1:0] ONE = N'(1);
  localparam int L = lbsm_pkg::LANES;

  // Size registers
  logic [N-1:0] sw_r, sh_r, tw_r, th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= '0;
      sh_r <= '0;
      tw_r <= '0;
      th_r <= '0;
    end else if (cfg_we) begin
      unique case (lbsm_pkg::cfg_idx_t'(cfg_index))
        lbsm_pkg::CFG_SOURCE_WIDTH:  sw_r <= cfg_data;
        lbsm_pkg::CFG_SOURCE_HEIGHT: sh_r <= cfg_data;
        lbsm_pkg::CFG_TARGET_WIDTH:  tw_r <= cfg_data;
        lbsm_pkg::CFG_TARGET_HEIGHT: th_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: capture coordinate and the two cross products
  logic           va_r, rdy_a;
  logic [N-1:0]   col_a_r, row_a_r;
  logic [2*N-1:0] sa_a_r, da_a_r;
  logic           div1_rdy;

  assign rdy_a    = !va_r || div1_rdy;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      col_a_r <= in_pixel_column;
      row_a_r <= in_pixel_row;
      sa_a_r  <= sw_r * th_r;
      da_a_r  <= tw_r * sh_r;
    end
  end

  // Fit extent division: lane 0 gives height candidate, lane 1 width candidate
  localparam int SW1 = 2 * N + 2;
  logic [L-1:0][2*N-1:0] div1_dvd;
  logic [L-1:0][N-1:0]   div1_dvs, div1_quo;
  logic [SW1-1:0]        div1_side_i, div1_side_o;
  logic                  div1_v;
  logic                  rdy_b;

  assign div1_dvd[0]  = da_a_r;
  assign div1_dvs[0]  = sw_r;
  assign div1_dvd[1]  = sa_a_r;
  assign div1_dvs[1]  = sh_r;
  assign div1_side_i  = {col_a_r, row_a_r, (sa_a_r > da_a_r), (sa_a_r < da_a_r)};

  lbsm_divider #(.N(N), .SW(SW1)) u_div_fit (
    .clk        (clk),
    .rst_n      (rst_n),
    .v_i        (va_r),
    .rdy_o      (div1_rdy),
    .dividend_i (div1_dvd),
    .divisor_i  (div1_dvs),
    .side_i     (div1_side_i),
    .v_o        (div1_v),
    .rdy_i      (rdy_b),
    .quo_o      (div1_quo),
    .side_o     (div1_side_o)
  );

  // Stage B: pick fitted width and height, a divided extent raised to at least one, then clamped to destination
  logic         vb_r;
  logic [N-1:0] col_b_r, row_b_r, pw_b_r, ph_b_r;
  logic [N-1:0] pw_sel, ph_sel, pw_fit, ph_fit;
  logic         wide_b, tall_b;
  logic         rdy_c;

  assign wide_b = div1_side_o[1];
  assign tall_b = div1_side_o[0];
  assign rdy_b  = !vb_r || rdy_c;

  always_comb begin
    priority if (wide_b) begin
      pw_sel = tw_r;
      ph_sel = (div1_quo[0] == '0) ? ONE : div1_quo[0];
    end else if (tall_b) begin
      pw_sel = (div1_quo[1] == '0) ? ONE : div1_quo[1];
      ph_sel = th_r;
    end else begin
      pw_sel = tw_r;
      ph_sel = th_r;
    end
    pw_fit = (pw_sel > tw_r) ? tw_r : pw_sel;
    ph_fit = (ph_sel > th_r) ? th_r : ph_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= div1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      col_b_r <= div1_side_o[2*N+1:N+2];
      row_b_r <= div1_side_o[N+1:2];
      pw_b_r  <= pw_fit;
      ph_b_r  <= ph_fit;
    end
  end

  // Stage C: centre the rectangle, classify the pixel, form offsets
  logic         vc_r;
  logic [N-1:0] px, py, offx_c_r, offy_c_r, pw_c_r, ph_c_r;
  logic [N:0]   endx, endy;
  logic         empty_c, oof_c, bar_c, lbox_c;
  logic         empty_c_r, oof_c_r, bar_c_r, lbox_c_r;
  logic         rdy_d;

  assign rdy_c   = !vc_r || rdy_d;
  assign px      = (tw_r - pw_b_r) >> 1;
  assign py      = (th_r - ph_b_r) >> 1;
  assign endx    = {1'b0, px} + {1'b0, pw_b_r};
  assign endy    = {1'b0, py} + {1'b0, ph_b_r};
  assign empty_c = (sw_r == '0) || (sh_r == '0) || (tw_r == '0) || (th_r == '0);
  assign oof_c   = (col_b_r >= tw_r) || (row_b_r >= th_r);
  assign lbox_c  = !empty_c && ((pw_b_r != tw_r) || (ph_b_r != th_r));
  assign bar_c   = !empty_c && !oof_c &&
                   ((col_b_r < px) || ({1'b0, col_b_r} >= endx) ||
                    (row_b_r < py) || ({1'b0, row_b_r} >= endy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      offx_c_r  <= col_b_r - px;
      offy_c_r  <= row_b_r - py;
      pw_c_r    <= pw_b_r;
      ph_c_r    <= ph_b_r;
      empty_c_r <= empty_c;
      oof_c_r   <= oof_c;
      bar_c_r   <= bar_c;
      lbox_c_r  <= lbox_c;
    end
  end

  // Stage D: scale offsets by the source extents
  logic           vd_r;
  logic [2*N-1:0] mx_d_r, my_d_r;
  logic [N-1:0]   pw_d_r, ph_d_r;
  logic [3:0]     flags_d_r;
  logic           div2_rdy;

  assign rdy_d = !vd_r || div2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (rdy_d) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      mx_d_r    <= offx_c_r * sw_r;
      my_d_r    <= offy_c_r * sh_r;
      pw_d_r    <= pw_c_r;
      ph_d_r    <= ph_c_r;
      flags_d_r <= {empty_c_r, oof_c_r, bar_c_r, lbox_c_r};
    end
  end

  // Source position division: lane 0 column, lane 1 row
  logic [L-1:0][2*N-1:0] div2_dvd;
  logic [L-1:0][N-1:0]   div2_dvs, div2_quo;
  logic [3:0]            div2_flags;
  logic                  div2_v, rdy_out;

  assign div2_dvd[0] = mx_d_r;
  assign div2_dvs[0] = pw_d_r;
  assign div2_dvd[1] = my_d_r;
  assign div2_dvs[1] = ph_d_r;

  lbsm_divider #(.N(N), .SW(4)) u_div_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .v_i        (vd_r),
    .rdy_o      (div2_rdy),
    .dividend_i (div2_dvd),
    .divisor_i  (div2_dvs),
    .side_i     (flags_d_r),
    .v_o        (div2_v),
    .rdy_i      (rdy_out),
    .quo_o      (div2_quo),
    .side_o     (div2_flags)
  );

  // Output register: clamp to extent minus one, zero outside the picture
  logic         ov_r;
  logic         empty_o_r, oof_o_r, bar_o_r, lbox_o_r;
  logic [N-1:0] sx_o_r, sy_o_r, sx_cl, sy_cl, sw_m1, sh_m1;
  logic         no_pic;

  assign rdy_out = !ov_r || !out_stall;
  assign sw_m1   = sw_r - ONE;
  assign sh_m1   = sh_r - ONE;
  assign sx_cl   = (div2_quo[0] > sw_m1) ? sw_m1 : div2_quo[0];
  assign sy_cl   = (div2_quo[1] > sh_m1) ? sh_m1 : div2_quo[1];
  assign no_pic  = div2_flags[3] || div2_flags[2] || div2_flags[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (rdy_out) begin
      ov_r <= div2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      empty_o_r <= div2_flags[3];
      oof_o_r   <= div2_flags[2];
      bar_o_r   <= div2_flags[1];
      lbox_o_r  <= div2_flags[0];
      sx_o_r    <= no_pic ? '0 : sx_cl;
      sy_o_r    <= no_pic ? '0 : sy_cl;
    end
  end

  assign out_valid         = ov_r;
  assign out_frame_empty   = empty_o_r;
  assign out_out_of_frame  = oof_o_r;
  assign out_in_bar        = bar_o_r;
  assign out_letterboxed   = lbox_o_r;
  assign out_source_column = sx_o_r;
  assign out_source_row    = sy_o_r;

`ifndef NO_ASSERTIONS
  a_bar_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(bar_o_r && (oof_o_r || empty_o_r)))
    else $error("bar flagged outside a valid frame");

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (bar_o_r || oof_o_r || empty_o_r)) |-> (sx_o_r == '0 && sy_o_r == '0))
    else $error("source position not zero outside the picture");

  a_empty_no_lbox: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && empty_o_r) |-> !lbox_o_r)
    else $error("letterbox flagged on empty frame");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !empty_o_r) |-> (sx_o_r < sw_r && sy_o_r < sh_r))
    else $error("source position beyond source extent");
`endif

endmodule

[dv/tb_letterbox_nearest_scaler_map_core.sv]
module tb_letterbox_nearest_scaler_map_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 15;
  localparam int LAT = 2 * CB + 5;

  typedef struct packed {
    logic          empty;
    logic          oof;
    logic          bar;
    logic          lbox;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
  } map_res_t;

  // Scoreboard: predicts each pixel mapping and checks returned beats in order
  class map_scoreboard;
    logic [CB-1:0] sw, sh, tw, th;
    map_res_t pending[$];
    int errors;

    function new();
      sw = '0; sh = '0; tw = '0; th = '0; errors = 0;
    endfunction

    function void set_reg(lbsm_pkg::cfg_idx_t idx, logic [CB-1:0] v);
      case (idx)
        lbsm_pkg::CFG_SOURCE_WIDTH:  sw = v;
        lbsm_pkg::CFG_SOURCE_HEIGHT: sh = v;
        lbsm_pkg::CFG_TARGET_WIDTH:  tw = v;
        default:                     th = v;
      endcase
    endfunction

    function logic [CB-1:0] scale_pos(longint unsigned off, longint unsigned src,
                                      longint unsigned fit);
      longint unsigned q;
      if (fit == 0 || src == 0) return '0;
      q = (off * src) / fit;
      if (q > src - 1) q = src - 1;
      return q[CB-1:0];
    endfunction

    function void note_pixel(logic [CB-1:0] col, logic [CB-1:0] row);
      map_res_t r;
      longint unsigned sa, da, pw, ph, px, py;
      r = '0;
      r.oof = (col >= tw) || (row >= th);
      if (sw == 0 || sh == 0 || tw == 0 || th == 0) begin
        r.empty = 1'b1;
      end else begin
        sa = longint'(sw) * th;
        da = longint'(tw) * sh;
        if (sa > da) begin
          pw = tw;
          ph = (longint'(tw) * sh) / sw;
          if (ph < 1) ph = 1;
        end else if (sa < da) begin
          ph = th;
          pw = (longint'(th) * sw) / sh;
          if (pw < 1) pw = 1;
        end else begin
          pw = tw;
          ph = th;
        end
        if (pw > tw) pw = tw;
        if (ph > th) ph = th;
        px = (tw - pw) / 2;
        py = (th - ph) / 2;
        r.lbox = (pw != tw) || (ph != th);
        if (!r.oof) begin
          if (col < px || col >= px + pw || row < py || row >= py + ph) begin
            r.bar = 1'b1;
          end else begin
            r.sx = scale_pos(col - px, sw, pw);
            r.sy = scale_pos(row - py, sh, ph);
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_beat(map_res_t got);
      map_res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lbsm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] in_pixel_column = '0;
  logic [CB-1:0] in_pixel_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_frame_empty, out_out_of_frame, out_in_bar, out_letterboxed;
  logic [CB-1:0] out_source_column, out_source_row;

  map_scoreboard sb = new();
  bit rx_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  letterbox_nearest_scaler_map_core #(.COORD_BITS(CB)) i_dut (.*);

  // Note accepted pixels and check accepted results at each edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_pixel_column, in_pixel_row);
    if (rst_n && out_valid && !out_stall)
      sb.check_beat({out_frame_empty, out_out_of_frame, out_in_bar, out_letterboxed,
                     out_source_column, out_source_row});
  end

  // Random receiver stalls, with quiet stretches
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = rx_quiet ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic write_reg(lbsm_pkg::cfg_idx_t idx, logic [CB-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_sizes(logic [CB-1:0] a, logic [CB-1:0] b, logic [CB-1:0] c,
                           logic [CB-1:0] d);
    write_reg(lbsm_pkg::CFG_SOURCE_WIDTH, a);
    write_reg(lbsm_pkg::CFG_SOURCE_HEIGHT, b);
    write_reg(lbsm_pkg::CFG_TARGET_WIDTH, c);
    write_reg(lbsm_pkg::CFG_TARGET_HEIGHT, d);
    cfg_we <= 1'b0;
  endtask

  // Drive one pixel beat, optionally after a random gap
  task automatic send_pixel(logic [CB-1:0] col, logic [CB-1:0] row, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 14) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_column <= col;
    in_pixel_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] rand_size(int mode);
    case (mode)
      0: return CB'($urandom_range(0, 3));
      1: return CB'($urandom_range(1, 64));
      2: return CB'($urandom_range(32700, 32767));
      default: return CB'($urandom);
    endcase
  endfunction

  initial begin
    logic [CB-1:0] c, r, m;
    int ph_items;
    bit gaps;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset sizes give empty frame, then extremes and special shapes
    send_pixel('0, '0, 0);
    send_pixel('1, '1, 0);
    drain();
    set_sizes(16, 9, 64, 64);
    send_pixel(0, 0, 0);
    send_pixel(10, 30, 0);
    send_pixel(63, 63, 0);
    send_pixel(64, 10, 0);
    send_pixel(10, 64, 0);
    drain();
    set_sizes(9, 16, 64, 64);
    send_pixel(0, 30, 0);
    send_pixel(30, 30, 0);
    send_pixel(40, 63, 0);
    drain();
    set_sizes(32767, 1, 32767, 32767);
    send_pixel(0, 16383, 0);
    send_pixel(32766, 16383, 0);
    send_pixel(100, 0, 0);
    drain();
    set_sizes(32767, 32767, 32767, 32767);
    send_pixel('1, '1, 0);
    send_pixel(32766, 32766, 0);
    send_pixel(0, 0, 0);
    drain();
    set_sizes(1, 1, 32767, 1);
    send_pixel(16383, 0, 0);
    send_pixel(0, 0, 0);
    drain();
    set_sizes(0, 5, 5, 5);
    send_pixel(2, 2, 0);
    send_pixel(9, 2, 0);
    drain();

    // Random phases: new sizes, then pixels mostly inside the target
    for (int p = 0; p < 40; p++) begin
      set_sizes(rand_size($urandom_range(0, 3)), rand_size($urandom_range(0, 3)),
                rand_size($urandom_range(0, 3)), rand_size($urandom_range(0, 3)));
      rx_quiet = ($urandom_range(0, 4) == 0);
      gaps = ($urandom_range(0, 4) != 0);
      ph_items = 50;
      for (int i = 0; i < ph_items; i++) begin
        m = CB'($urandom_range(0, 9));
        if (m < 7 && sb.tw != 0 && sb.th != 0) begin
          c = CB'($urandom_range(0, sb.tw - 1));
          r = CB'($urandom_range(0, sb.th - 1));
        end else begin
          c = CB'($urandom);
          r = CB'($urandom);
        end
        send_pixel(c, r, gaps);
        // Hold off the sender until the pipeline is empty
        if (i == 25 && p % 8 == 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    rx_quiet = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
